// ===== hdl/ppb_pkg.sv =====
// Package for positive_min_max_power_bounds: payload types, constants, helpers.
package ppb_pkg;

  localparam logic [63:0] EXP_MASK  = 64'h7ff0_0000_0000_0000;
  localparam logic [63:0] FRAC_MASK = 64'h000f_ffff_ffff_ffff;
  localparam logic [63:0] EXP_ONE   = 64'h0010_0000_0000_0000;
  localparam logic [63:0] DMAX_BITS = 64'h7fef_ffff_ffff_ffff;
  // INT_MAX (2147483647) as binary64
  localparam logic [63:0] IMAX_BITS = 64'h41df_ffff_ffc0_0000;
  localparam logic [10:0] EXP_BIAS  = 11'd1023;

  localparam logic KIND_DOUBLE = 1'b0;
  localparam logic KIND_INT    = 1'b1;

  typedef struct packed {
    logic [63:0] sample_bits;
    logic        last_item;
  } in_t;

  typedef struct packed {
    logic [63:0] lower_power;
    logic [63:0] upper_power;
    logic        all_valid;
  } out_t;

  // index of highest set bit of a 31-bit value (0 when zero)
  function automatic logic [4:0] top_bit31(input logic [30:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // index of highest set bit of a 52-bit fraction (0 when zero)
  function automatic logic [5:0] top_bit52(input logic [51:0] v);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 52; i++) begin
      if (v[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

// ===== hdl/positive_min_max_power_bounds.sv =====
// Top level of positive_min_max_power_bounds: streaming min/max power-of-two bounds.
//
// Takes one vector element per transfer (binary64 or signed 32-bit integer, chosen by the
// one-bit cfg register, 0 = double, 1 = integer) and on the transfer flagged last_item
// emits one result: the largest power of two at or below the running minimum, the
// smallest power of two at or above the running maximum (binary64 patterns, subnormals
// included, infinity when the maximum overflows the top binade) and all_valid. Any zero,
// negative, infinite or NaN element clears all_valid and zeroes both bounds. One element
// is accepted every cycle unless a result waits on out_ready; the only loop is the
// min/max compare-and-update register. A result passes through the input register,
// integer-to-double conversion, min/max update, and bound computation into the output
// register. All stages stall together while a result waits on out_ready. Change the
// element kind only while no vector is in flight; the running state is restored to its
// reset values (minimum start depends on the kind in force) after each last element.
module positive_min_max_power_bounds
  import ppb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic en;
  logic kind_r;

  // stage 1: input register
  logic        s1_valid_r;
  in_t         s1_data_r;
  logic        s1_kind_r;

  // stage 2: element as binary64, with validity
  logic        s2_valid_r, s2_valid_nxt;
  logic [63:0] s2_v_r, s2_v_nxt;
  logic        s2_ok_r, s2_ok_nxt;
  logic        s2_last_r;
  logic        s2_kind_r;

  // running state
  logic [63:0] min_r, min_nxt;
  logic [63:0] max_r, max_nxt;
  logic        bad_r, bad_nxt;

  // stage 3: final min/max of a finished vector
  logic        s3_valid_r;
  logic [63:0] s3_min_r, s3_max_r;
  logic        s3_bad_r;

  logic        out_valid_r;
  out_t        out_data_r, out_data_nxt;

  // whole pipeline advances unless a result is stuck at the output
  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= KIND_DOUBLE;
    end else if (cfg_valid) begin
      kind_r <= cfg_data;
    end
  end

  // element decode and exact int -> double conversion
  always_comb begin
    logic [31:0] w;
    logic [4:0]  p;
    logic [30:0] mant;
    logic [10:0] ex;
    w    = s1_data_r.sample_bits[31:0];
    p    = top_bit31(w[30:0]);
    mant = w[30:0] << (5'd30 - p);
    ex   = EXP_BIAS + {6'd0, p};
    s2_valid_nxt = s1_valid_r;
    if (s1_kind_r == KIND_INT) begin
      s2_ok_nxt = (w != 32'd0) && !w[31];
      s2_v_nxt  = {1'b0, ex, mant[29:0], 22'd0};
    end else begin
      s2_ok_nxt = !s1_data_r.sample_bits[63]
               && ((s1_data_r.sample_bits & EXP_MASK) != EXP_MASK)
               && (s1_data_r.sample_bits != 64'd0);
      s2_v_nxt  = s1_data_r.sample_bits;
    end
  end

  // running min/max; positive doubles order like their bit patterns
  always_comb begin
    logic [63:0] nmin, nmax;
    logic        nbad;
    nmin = min_r;
    nmax = max_r;
    nbad = bad_r;
    if (s2_ok_r) begin
      if (s2_v_r < min_r) nmin = s2_v_r;
      if (s2_v_r > max_r) nmax = s2_v_r;
    end else begin
      nbad = 1'b1;
    end
    min_nxt = nmin;
    max_nxt = nmax;
    bad_nxt = nbad;
  end

  // power-of-two bounds of the finished vector
  always_comb begin
    logic [63:0] emin, fmin, emax, fmax, lo, hi;
    logic [5:0]  pmin, pmax;
    emin = s3_min_r & EXP_MASK;
    fmin = s3_min_r & FRAC_MASK;
    emax = s3_max_r & EXP_MASK;
    fmax = s3_max_r & FRAC_MASK;
    pmin = top_bit52(fmin[51:0]);
    pmax = top_bit52(fmax[51:0]);
    if (emin != 64'd0)      lo = emin;
    else if (fmin == 64'd0) lo = 64'd0;
    else                    lo = 64'd1 << pmin;
    if (emax != 64'd0)                   hi = (fmax == 64'd0) ? emax : emax + EXP_ONE;
    else if (fmax == 64'd0)              hi = 64'd0;
    else if (fmax == (64'd1 << pmax))    hi = fmax;
    else                                 hi = 64'd1 << (pmax + 6'd1);
    if (s3_bad_r) begin
      out_data_nxt = '0;
    end else begin
      out_data_nxt.lower_power = lo;
      out_data_nxt.upper_power = hi;
      out_data_nxt.all_valid   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      min_r       <= DMAX_BITS;
      max_r       <= 64'd0;
      bad_r       <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s2_valid_r && s2_last_r;
      out_valid_r <= s3_valid_r;
      if (s2_valid_r) begin
        if (s2_last_r) begin
          // vector done: restore start values for the kind in force
          min_r <= (s2_kind_r == KIND_INT) ? IMAX_BITS : DMAX_BITS;
          max_r <= 64'd0;
          bad_r <= 1'b0;
        end else begin
          min_r <= min_nxt;
          max_r <= max_nxt;
          bad_r <= bad_nxt;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (en) begin
      s1_data_r  <= in_data;
      s1_kind_r  <= kind_r;
      s2_v_r     <= s2_v_nxt;
      s2_ok_r    <= s2_ok_nxt;
      s2_last_r  <= s1_data_r.last_item;
      s2_kind_r  <= s1_kind_r;
      s3_min_r   <= min_nxt;
      s3_max_r   <= max_nxt;
      s3_bad_r   <= bad_nxt;
      out_data_r <= out_data_nxt;
    end
  end

`ifndef SYNTHESIS
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.all_valid |->
      out_data_r.lower_power == 64'd0 && out_data_r.upper_power == 64'd0)
    else $error("invalid vector with nonzero bounds");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.all_valid |->
      out_data_r.lower_power <= out_data_r.upper_power)
    else $error("lower bound above upper bound");

  a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    en && s2_valid_r && s2_last_r |=>
      max_r == 64'd0 && !bad_r &&
      min_r == (($past(s2_kind_r) == KIND_INT) ? IMAX_BITS : DMAX_BITS))
    else $error("running state not restored after last element");

  a_result_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
    en && s3_valid_r |=> out_valid_r)
    else $error("finished vector gave no result");
`endif

endmodule

// ===== tb/ppb_checker.sv =====
// Checker for positive_min_max_power_bounds: watches the channels, predicts bounds, compares.
module ppb_checker
  import ppb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic cfg_data,
  output int   fail_count,
  output int   bounds_pending,
  output int   bounds_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  logic        kind;
  logic [63:0] run_min;
  logic [63:0] run_max;
  logic        saw_bad;
  out_t        bounds_q[$];

  function automatic logic [63:0] min_start(input logic k);
    return (k == KIND_INT) ? IMAX_BITS : DMAX_BITS;
  endfunction

  function automatic int msb_of(input logic [63:0] v);
    int p;
    p = 0;
    for (int i = 0; i < 64; i++) if (v[i]) p = i;
    return p;
  endfunction

  function automatic logic [63:0] pow_floor(input logic [63:0] b);
    logic [63:0] f;
    f = b & FRAC_MASK;
    if ((b & EXP_MASK) != 0) return b & EXP_MASK;
    if (f == 0) return 64'd0;
    return 64'd1 << msb_of(f);
  endfunction

  function automatic logic [63:0] pow_ceil(input logic [63:0] b);
    logic [63:0] e;
    logic [63:0] f;
    int p;
    e = b & EXP_MASK;
    f = b & FRAC_MASK;
    if (e != 0) return (f == 0) ? e : e + EXP_ONE;
    if (f == 0) return 64'd0;
    p = msb_of(f);
    if (f == (64'd1 << p)) return f;
    return 64'd1 << (p + 1);
  endfunction

  // exact int -> binary64 for a positive 31-bit value
  function automatic logic [63:0] int_to_dbl(input logic [30:0] w);
    int p;
    logic [63:0] m;
    p = msb_of({33'd0, w});
    m = {33'd0, w} << (52 - p);
    return {1'b0, 11'(1023 + p), m[51:0]};
  endfunction

  always @(posedge clk) begin
    logic [63:0] s;
    logic [63:0] v;
    logic        ok;
    logic [31:0] w;
    out_t        exp_r;
    if (!rst_n) begin
      kind <= KIND_DOUBLE;
      run_min <= DMAX_BITS;
      run_max <= '0;
      saw_bad <= 1'b0;
      fail_count <= 0;
      bounds_checked <= 0;
      bounds_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        // the running minimum keeps its start value until the next vector ends
        kind <= cfg_data;
      end
      if (in_valid && in_ready) begin
        s = in_data.sample_bits;
        if (kind == KIND_INT) begin
          w = s[31:0];
          ok = (w != 0) && !w[31];
          v = ok ? int_to_dbl(w[30:0]) : 64'd0;
        end else begin
          ok = !s[63] && ((s & EXP_MASK) != EXP_MASK) && (s != 0);
          v = s;
        end
        if (in_data.last_item) begin
          if (!(saw_bad || !ok)) begin
            exp_r.lower_power = pow_floor((ok && v < run_min) ? v : run_min);
            exp_r.upper_power = pow_ceil((ok && v > run_max) ? v : run_max);
            exp_r.all_valid = 1'b1;
          end else begin
            exp_r = '0;
          end
          bounds_q.push_back(exp_r);
          run_min <= min_start(kind);
          run_max <= '0;
          saw_bad <= 1'b0;
        end else if (ok) begin
          if (v < run_min) run_min <= v;
          if (v > run_max) run_max <= v;
        end else begin
          saw_bad <= 1'b1;
        end
      end
      if (out_valid && out_ready) begin
        bounds_checked <= bounds_checked + 1;
        if (bounds_q.size() == 0) begin
          $error("unexpected result transfer: %p", out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = bounds_q.pop_front();
          if (out_data.lower_power !== exp_r.lower_power) begin
            $error("lower_power expected %h actual %h", exp_r.lower_power,
                   out_data.lower_power);
            fail_count <= fail_count + 1;
          end
          if (out_data.upper_power !== exp_r.upper_power) begin
            $error("upper_power expected %h actual %h", exp_r.upper_power,
                   out_data.upper_power);
            fail_count <= fail_count + 1;
          end
          if (out_data.all_valid !== exp_r.all_valid) begin
            $error("all_valid expected %0b actual %0b", exp_r.all_valid,
                   out_data.all_valid);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  assign bounds_pending = bounds_q.size();

endmodule

// ===== tb/positive_min_max_power_bounds_test.sv =====
// Testbench top for positive_min_max_power_bounds: stimulus, pacing and verdict.
module positive_min_max_power_bounds_test;
  import ppb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 480;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  logic in_valid, in_ready;
  in_t  in_data;
  logic out_valid, out_ready;
  out_t out_data;
  logic cfg_valid, cfg_ready, cfg_data;
  int   fail_count, bounds_pending, bounds_checked;
  int   cycle_count;
  int   sent_count;
  bit   long_hold;   // request from stimulus for a long receiver stall
  int   vec_count [2];

  positive_min_max_power_bounds u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ppb_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .bounds_pending(bounds_pending),
    .bounds_checked(bounds_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("Timeout after %0d cycles", cycle_count);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Receiver: random stall per result, plus one long hold-off on request so the
  // pipeline backs up and pushes back on in_ready.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk iff out_valid);
    end
  end

  // One element transfer; valid stays up until accepted.
  task automatic send_sample(input logic [63:0] bits, input logic last, input bit paced);
    int gap;
    gap = (paced && $urandom_range(0, 2) != 0) ? $urandom_range(0, 19) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{sample_bits: bits, last_item: last};
    @(posedge clk iff in_ready);
    sent_count++;
    if (last) vec_count[cfg_data]++;
  endtask

  // Register write, only with nothing in flight.
  task automatic write_kind(input logic k);
    in_valid <= 1'b0;
    @(posedge clk iff bounds_pending == 0);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= k;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Random positive double: normal, subnormal, exact powers, top binade.
  function automatic logic [63:0] good_double();
    logic [63:0] f;
    f = {$urandom, $urandom} & FRAC_MASK;
    case ($urandom_range(0, 5))
      0: return {1'b0, 11'd0, (f[51:0] == 0) ? 52'd1 : f[51:0]};
      1: return {1'b0, 11'($urandom_range(1, 2046)), 52'd0};
      2: return {1'b0, 11'd2046, f[51:0]};
      3: return 64'd1 << $urandom_range(0, 51);
      default: return {1'b0, 11'($urandom_range(1, 2046)), f[51:0]};
    endcase
  endfunction

  function automatic logic [63:0] bad_double();
    case ($urandom_range(0, 4))
      0: return 64'd0;
      1: return {1'b1, 63'({$urandom, $urandom})};
      2: return EXP_MASK;
      3: return EXP_MASK | ({$urandom, $urandom} & FRAC_MASK) | 64'd1;
      default: return {1'b1, 63'd0};
    endcase
  endfunction

  // Random integer element; upper word is junk the block must ignore.
  function automatic logic [63:0] int_elem(input bit good);
    logic [31:0] w;
    if (good) begin
      case ($urandom_range(0, 3))
        0: w = 32'd1 << $urandom_range(0, 30);
        1: w = $urandom_range(1, 255);
        default: w = {1'b0, 31'($urandom)} | 32'd1;
      endcase
    end else begin
      w = ($urandom_range(0, 2) == 0) ? 32'd0 : ($urandom | 32'h8000_0000);
    end
    return {$urandom, w};
  endfunction

  task automatic random_vectors(input logic k, input int n_items);
    int len, i, done;
    bit good;
    done = 0;
    while (done < n_items) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
      for (i = 0; i < len; i++) begin
        // most vectors are clean so the bound path is reached
        good = ($urandom_range(0, 24) != 0);
        send_sample((k == KIND_INT) ? int_elem(good) : (good ? good_double() : bad_double()),
                    i == len - 1, 1'b1);
        done++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = KIND_DOUBLE;
    long_hold = 1'b0;
    sent_count = 0;
    vec_count = '{0, 0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed doubles: smallest subnormal, largest finite (top-binade overflow to inf),
    // exact power, largest subnormal with smallest normal, then each invalid kind.
    send_sample(64'd1, 1'b1, 1'b0);
    send_sample(DMAX_BITS, 1'b1, 1'b0);
    send_sample(64'h3ff0_0000_0000_0000, 1'b1, 1'b0);
    send_sample(64'h000f_ffff_ffff_ffff, 1'b0, 1'b0);
    send_sample(64'h0010_0000_0000_0000, 1'b1, 1'b0);
    send_sample(64'h4008_0000_0000_0000, 1'b0, 1'b0);
    send_sample(64'd0, 1'b1, 1'b0);
    send_sample(64'h8000_0000_0000_0001, 1'b1, 1'b0);
    send_sample(EXP_MASK, 1'b1, 1'b0);
    send_sample(64'h7ff8_0000_0000_0000, 1'b1, 1'b0);
    send_sample(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);

    // Integers: one, INT_MAX, a clean pair, zero, most negative, a pair ending negative; high word garbage.
    write_kind(KIND_INT);
    send_sample(64'd1, 1'b1, 1'b0);
    send_sample(64'hffff_ffff_7fff_ffff, 1'b1, 1'b0);
    send_sample(64'd5, 1'b0, 1'b0);
    send_sample(64'd1000, 1'b1, 1'b0);
    send_sample(64'hffff_ffff_0000_0000, 1'b1, 1'b0);
    send_sample(64'h0000_0000_8000_0000, 1'b1, 1'b0);
    send_sample(64'd3, 1'b0, 1'b0);
    send_sample(64'hffff_ffff_ffff_ffff, 1'b1, 1'b0);

    // Back-pressure: receiver holds off while the sender keeps streaming.
    long_hold = 1'b1;
    for (int i = 0; i < 40; i++) send_sample(int_elem(1'b1), 1'(i % 2), 1'b0);

    random_vectors(KIND_INT, RANDOM_ITEMS / 4);
    write_kind(KIND_DOUBLE);
    random_vectors(KIND_DOUBLE, RANDOM_ITEMS / 4);
    write_kind(KIND_INT);
    random_vectors(KIND_INT, RANDOM_ITEMS / 4);
    write_kind(KIND_DOUBLE);
    random_vectors(KIND_DOUBLE, RANDOM_ITEMS / 4);
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency to flush any stray output.
    @(posedge clk iff bounds_pending == 0);
    repeat (20) @(posedge clk);
    $display("Sent %0d elements; %0d double and %0d integer vectors, %0d results checked",
             sent_count, vec_count[0], vec_count[1], bounds_checked);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/ppb_pkg.sv
hdl/positive_min_max_power_bounds.sv
tb/ppb_checker.sv
tb/positive_min_max_power_bounds_test.sv
